// ===== rtl/hwbe_pkg.sv =====
package hwbe_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] RUN_LIMIT = 3'd7;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [3:0] LIT_LEN   = 4'd9;
    localparam logic [3:0] MATCH_LEN = 4'd5;
    localparam logic [3:0] COUNT_LEN = 4'd3;
    localparam logic [3:0] EMPTY_LEN = 4'd0;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } hwbe_in_t;

    typedef struct packed {
        logic [8:0] code_bits;
        logic [3:0] code_length;
        logic       last;
    } hwbe_out_t;

    typedef struct packed {
        logic       is_end;
        logic [7:0] symbol;
    } hwbe_cmd_t;

    typedef struct packed {
        logic      valid;
        hwbe_cmd_t cmd;
    } hwbe_head_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_MATCHED = 2'd1,
        MODE_RUN     = 2'd2
    } hwbe_mode_t;

endpackage

// ===== rtl/hwbe_front.sv =====
module hwbe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  hwbe_pkg::hwbe_in_t byte_item,
    output hwbe_pkg::hwbe_head_t head,
    input  logic               pop
);

    hwbe_pkg::hwbe_cmd_t             entry_reg [hwbe_pkg::QUEUE_DEPTH];
    logic [hwbe_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [hwbe_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [hwbe_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            full;
    logic                            push;
    logic                            pop_ok;
    hwbe_pkg::hwbe_cmd_t             cmd_in;

    assign full       = (count_reg == hwbe_pkg::QCNT_W'(hwbe_pkg::QUEUE_DEPTH));
    assign byte_stall = full;
    assign push       = byte_valid && !full;
    assign pop_ok     = pop && (count_reg != '0);

    // classify the beat: end marker or data symbol
    always_comb
    begin
        cmd_in.is_end = (byte_item.operation == hwbe_pkg::OP_END);
        cmd_in.symbol = byte_item.data_byte;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == hwbe_pkg::QPTR_W'(hwbe_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + hwbe_pkg::QPTR_W'(1);
        end
        if (pop_ok)
        begin
            if (rd_ptr_reg == hwbe_pkg::QPTR_W'(hwbe_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + hwbe_pkg::QPTR_W'(1);
        end
        case ({push, pop_ok})
            2'b10:   count_next = count_reg + hwbe_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - hwbe_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

// ===== rtl/hwbe_back.sv =====
module hwbe_back #(
    parameter int HISTORY_DEPTH = hwbe_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hwbe_pkg::hwbe_head_t head,
    output logic                 pop,
    output logic                 token_valid,
    input  logic                 token_stall,
    output hwbe_pkg::hwbe_out_t  token_item
);

    logic [7:0]           hist_reg [HISTORY_DEPTH];
    logic [7:0]           hist_next [HISTORY_DEPTH];
    logic [7:0]           hist_a [HISTORY_DEPTH];
    logic [7:0]           hist_b [HISTORY_DEPTH];
    hwbe_pkg::hwbe_mode_t mode_reg, mode_next;
    logic                 started_reg, started_next;
    logic [7:0]           held_reg, held_next;
    logic [2:0]           pos_reg, pos_next;
    logic [2:0]           run_count_reg, run_count_next;

    logic                 out_valid_reg, out_valid_next;
    hwbe_pkg::hwbe_out_t  out_item_reg, out_item_next;
    logic                 pend_valid_reg, pend_valid_next;
    hwbe_pkg::hwbe_out_t  pend_item_reg, pend_item_next;

    logic                 take;
    logic                 is_end;
    logic [7:0]           symbol;
    logic                 is_matched;
    logic                 is_run;
    logic                 same;
    logic                 run_more;
    logic                 shift_held;
    logic                 pre_valid;
    logic                 fresh;
    logic                 found;
    logic [2:0]           found_pos;
    logic                 fresh_lit;
    logic                 fresh_hold;
    hwbe_pkg::hwbe_out_t  pre_tok;
    hwbe_pkg::hwbe_out_t  lit_tok;
    hwbe_pkg::hwbe_out_t  end_tok;
    hwbe_pkg::hwbe_out_t  tok0, tok1;
    logic                 tok0_valid, tok1_valid;

    assign take = head.valid && !pend_valid_reg && (!out_valid_reg || !token_stall);
    assign pop  = take;

    assign is_end     = head.cmd.is_end;
    assign symbol     = head.cmd.symbol;
    assign is_matched = (mode_reg == hwbe_pkg::MODE_MATCHED);
    assign is_run     = (mode_reg == hwbe_pkg::MODE_RUN);
    assign same       = (symbol == held_reg);
    assign run_more   = same && (run_count_reg < hwbe_pkg::RUN_LIMIT);

    assign shift_held = !is_end && ((is_matched && !same) || (is_run && run_more));
    assign pre_valid  = !is_end && (is_matched || (is_run && !run_more));
    assign fresh      = !is_end && ((!is_matched && !is_run) || (is_matched && !same)
                                    || (is_run && !run_more));
    assign fresh_lit  = fresh && (!started_reg || !found);
    assign fresh_hold = fresh && started_reg && found;

    // history as seen by the fresh search, after the held symbol goes in
    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (!shift_held)
                hist_a[i] = hist_reg[i];
            else if (i == 0)
                hist_a[i] = held_reg;
            else
                hist_a[i] = hist_reg[i-1];
        end
    end

    // newest matching entry wins
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = HISTORY_DEPTH - 1; i >= 0; i--)
        begin
            if (hist_a[i] == symbol)
            begin
                found     = 1'b1;
                found_pos = 3'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (!fresh_lit)
                hist_b[i] = hist_a[i];
            else if (i == 0)
                hist_b[i] = symbol;
            else
                hist_b[i] = hist_a[i-1];
        end
    end

    // mode sequencing
    always_comb
    begin
        mode_next = mode_reg;
        if (take)
        begin
            if (is_end)
                mode_next = hwbe_pkg::MODE_IDLE;
            else
            begin
                unique case (mode_reg)
                    hwbe_pkg::MODE_MATCHED:
                    begin
                        if (same)
                            mode_next = hwbe_pkg::MODE_RUN;
                        else if (fresh_hold)
                            mode_next = hwbe_pkg::MODE_MATCHED;
                        else
                            mode_next = hwbe_pkg::MODE_IDLE;
                    end
                    hwbe_pkg::MODE_RUN:
                    begin
                        if (run_more)
                            mode_next = hwbe_pkg::MODE_RUN;
                        else if (fresh_hold)
                            mode_next = hwbe_pkg::MODE_MATCHED;
                        else
                            mode_next = hwbe_pkg::MODE_IDLE;
                    end
                    default:
                    begin
                        if (fresh_hold)
                            mode_next = hwbe_pkg::MODE_MATCHED;
                        else
                            mode_next = hwbe_pkg::MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // tokens
    always_comb
    begin
        if (is_matched)
        begin
            pre_tok.code_bits   = same ? {5'b0, 1'b1, pos_reg} : {6'b0, pos_reg};
            pre_tok.code_length = hwbe_pkg::MATCH_LEN;
        end
        else
        begin
            pre_tok.code_bits   = {6'b0, run_count_reg};
            pre_tok.code_length = hwbe_pkg::COUNT_LEN;
        end
        pre_tok.last = 1'b0;

        lit_tok.code_bits   = {1'b1, symbol};
        lit_tok.code_length = hwbe_pkg::LIT_LEN;
        lit_tok.last        = 1'b0;

        if (is_matched)
        begin
            end_tok.code_bits   = {6'b0, pos_reg};
            end_tok.code_length = hwbe_pkg::MATCH_LEN;
        end
        else if (is_run)
        begin
            end_tok.code_bits   = {6'b0, run_count_reg};
            end_tok.code_length = hwbe_pkg::COUNT_LEN;
        end
        else
        begin
            end_tok.code_bits   = '0;
            end_tok.code_length = hwbe_pkg::EMPTY_LEN;
        end
        end_tok.last = 1'b1;

        tok1       = lit_tok;
        tok1_valid = 1'b0;
        if (is_end)
        begin
            tok0       = end_tok;
            tok0_valid = 1'b1;
        end
        else if (pre_valid)
        begin
            tok0       = pre_tok;
            tok0_valid = 1'b1;
            tok1_valid = fresh_lit;
        end
        else
        begin
            tok0       = lit_tok;
            tok0_valid = fresh_lit;
        end
    end

    // encoder state
    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist_next[i] = hist_reg[i];
        started_next   = started_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        run_count_next = run_count_reg;
        if (take)
        begin
            if (is_end)
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                    hist_next[i] = '0;
                started_next   = 1'b0;
                held_next      = '0;
                pos_next       = '0;
                run_count_next = '0;
            end
            else
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                    hist_next[i] = hist_b[i];
                started_next = started_reg || fresh;
                if (fresh_hold)
                begin
                    held_next = symbol;
                    pos_next  = found_pos;
                end
                if (is_run && run_more)
                    run_count_next = run_count_reg + 3'd1;
                else if (is_matched || is_run)
                    run_count_next = '0;
            end
        end
    end

    // output register plus one hold slot for a second token
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        pend_valid_next = pend_valid_reg;
        pend_item_next  = pend_item_reg;
        if (out_valid_reg && !token_stall)
            out_valid_next = 1'b0;
        if (take)
        begin
            if (tok0_valid)
            begin
                out_valid_next = 1'b1;
                out_item_next  = tok0;
            end
            pend_valid_next = tok1_valid;
            pend_item_next  = tok1;
        end
        else if (pend_valid_reg && (!out_valid_reg || !token_stall))
        begin
            out_valid_next  = 1'b1;
            out_item_next   = pend_item_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
            mode_reg       <= hwbe_pkg::MODE_IDLE;
            started_reg    <= 1'b0;
            held_reg       <= '0;
            pos_reg        <= '0;
            run_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= hist_next[i];
            mode_reg       <= mode_next;
            started_reg    <= started_next;
            held_reg       <= held_next;
            pos_reg        <= pos_next;
            run_count_reg  <= run_count_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        pend_item_reg <= pend_item_next;
    end

    assign token_valid = out_valid_reg;
    assign token_item  = out_item_reg;

endmodule

// ===== rtl/history_window_byte_encoder_top.sv =====
// byte history encoder: literal, match, and run-count tokens against a short
// shift history of the most recent bytes
// byte channel: byte_valid / byte_stall / byte_item, one data byte or end
// marker per beat; a two-entry queue takes beats while the encoder is busy,
// and byte_stall rises only when that queue is full
// token channel: token_valid / token_stall / token_item, one token per beat,
// code_bits right-aligned, code_length 9, 5, 3 or 0, last set on the token
// that an end marker produces
// a beat moves from its queue entry into the output register
// throughput: the encoder takes one queued item per cycle while the hold
// slot is empty and the output register is free or draining; an item that
// yields two tokens parks the second in the one-token hold slot, and no new
// item is taken until that slot drains; bytes that extend a run yield no token
// a stalled token holds in the output register while the queue keeps
// taking beats until it is full
// reset clears the queue, the output, the history and all match state;
// an end marker returns the history and match state to that same state
module history_window_byte_encoder_top #(
    parameter int HISTORY_DEPTH = hwbe_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  hwbe_pkg::hwbe_in_t  byte_item,
    output logic                token_valid,
    input  logic                token_stall,
    output hwbe_pkg::hwbe_out_t token_item
);

    hwbe_pkg::hwbe_head_t head;
    logic                 pop;

    hwbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .head       (head),
        .pop        (pop)
    );

    hwbe_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    // only legal token lengths
    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> (token_item.code_length == hwbe_pkg::LIT_LEN
                      || token_item.code_length == hwbe_pkg::MATCH_LEN
                      || token_item.code_length == hwbe_pkg::COUNT_LEN
                      || token_item.code_length == hwbe_pkg::EMPTY_LEN))
        else $error("illegal token length");

    // an empty token comes only from an end marker
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_item.code_length == hwbe_pkg::EMPTY_LEN)
            |-> token_item.last)
        else $error("empty token without last");

    // end marker never yields a literal
    a_last_no_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_item.last) |-> token_item.code_length != hwbe_pkg::LIT_LEN)
        else $error("literal marked last");

    // bits 8 to 5 stay clear on every token shorter than a literal
    a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_item.code_length != hwbe_pkg::LIT_LEN)
            |-> token_item.code_bits[8:5] == 4'b0)
        else $error("stray high token bits");

endmodule
